FILE: hdl/deq_pkg.sv
`default_nettype none
package deq_pkg;

   typedef enum logic [3:0] {
      FN_PUSH_FRONT = 4'd0,
      FN_PUSH_BACK  = 4'd1,
      FN_POP_FRONT  = 4'd2,
      FN_POP_BACK   = 4'd3,
      FN_SORT       = 4'd4,
      FN_REVERSE    = 4'd5,
      FN_SHOW       = 4'd6,
      FN_SIZE       = 4'd7,
      FN_PEEK_FRONT = 4'd8,
      FN_PEEK_BACK  = 4'd9,
      FN_CLEAR      = 4'd10
   } func_type;

   typedef enum logic [1:0] {
      KIND_ELEM  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_SIZE  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SORT_WR,
      ST_REV_RD,
      ST_REV_WR,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_OUT,
      ST_ONE_OUT
   } state_type;

   // Datapath operations selected by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_CLEAR,
      OP_SORT_INIT,
      OP_SORT_RD,
      OP_SORT_CMP,
      OP_SORT_WR,
      OP_REV_INIT,
      OP_REV_RD,
      OP_REV_WR,
      OP_EMIT_INIT,
      OP_EMIT_RD
   } op_type;

   typedef struct packed {
      op_type   op;
      logic     one_load;
      kind_type one_kind;
      logic     one_sel_count;
      logic     one_sel_front;
   } cmd_type;

   typedef struct packed {
      logic     full;
      logic     empty;
      logic     sort_done;
      logic     swap_needed;
      logic     rev_done;
      logic     emit_last;
      func_type func;
   } status_type;

endpackage
`default_nettype wire

FILE: hdl/deq_if.sv
`default_nettype none
interface deq_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  func;
   logic signed [31:0] value;
   modport source (output valid, output func, output value, input ready);
   modport sink (input valid, input func, input value, output ready);
endinterface

interface deq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic signed [31:0] value_res;
   logic        last;
   modport source (output valid, output kind, output value_res, output last, input ready);
   modport sink (input valid, input kind, input value_res, input last, output ready);
endinterface
`default_nettype wire

FILE: hdl/deq_datapath.sv
`default_nettype none
module deq_datapath #(
   parameter int CAPACITY = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire deq_pkg::cmd_type     cmd,
   output deq_pkg::status_type       status,
   input  wire logic [3:0]           req_func,
   input  wire logic signed [31:0]   req_value,
   output logic [1:0]                out_kind,
   output logic signed [31:0]        out_value,
   output logic                      out_last
);
   import deq_pkg::*;

   localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   logic signed [31:0] mem [CAPACITY];

   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [3:0]    func_ff;
   logic signed [31:0] val_ff;
   // Walk indexes are logical positions from the front.
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [31:0] a_ff, b_ff, rd_ff;
   logic          swap_now;
   logic [1:0]    kind_ff;
   logic signed [31:0] oval_ff;
   logic          last_ff;
   logic          last_is_stream;

   logic [IW-1:0] wr_addr, rd_addr;
   logic          wr_en;
   logic          rd_en;
   logic signed [31:0] wr_data;

   function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] i);
      logic [CW:0] s;
      s = {1'b0, CW'(h)} + {1'b0, i};
      if (s >= {1'b0, CAP}) s = s - {1'b0, CAP};
      return s[IW-1:0];
   endfunction

   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = val_ff;
      rd_addr = '0;
      rd_en = 1'b0;
      case (cmd.op)
         OP_PUSH_FRONT: begin
            head_in = (head_ff == '0) ? IW'(CAPACITY - 1) : head_ff - 1'b1;
            wr_en = 1'b1;
            wr_addr = head_in;
            count_in = count_ff + 1'b1;
            i_in = '0;
         end
         OP_PUSH_BACK: begin
            wr_en = 1'b1;
            wr_addr = slot(head_ff, count_ff);
            count_in = count_ff + 1'b1;
            i_in = '0;
         end
         OP_POP_FRONT: begin
            head_in = slot(head_ff, CW'(1));
            count_in = count_ff - 1'b1;
            i_in = '0;
         end
         OP_POP_BACK: begin
            count_in = count_ff - 1'b1;
            i_in = '0;
         end
         OP_CLEAR: begin
            head_in = '0;
            count_in = '0;
         end
         OP_SORT_INIT: begin
            // Pass bound k, position i; bubble passes.
            k_in = count_ff - 1'b1;
            i_in = '0;
         end
         OP_SORT_RD: begin
            rd_addr = slot(head_ff, i_ff);
            rd_en = 1'b1;
         end
         OP_SORT_CMP: begin
            rd_addr = slot(head_ff, i_ff + 1'b1);
            rd_en = 1'b1;
         end
         OP_SORT_WR: begin
            if (swap_now) begin
               wr_en = 1'b1;
               wr_addr = slot(head_ff, i_ff);
               wr_data = rd_ff;
            end
            if (i_ff + 1'b1 >= k_ff) begin
               i_in = '0;
               k_in = k_ff - 1'b1;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         OP_REV_INIT: begin
            i_in = '0;
            j_in = count_ff - 1'b1;
         end
         OP_REV_RD: rd_addr = slot(head_ff, i_ff);
         OP_REV_WR: begin
            wr_en = 1'b1;
            wr_addr = slot(head_ff, i_ff);
            wr_data = b_ff;
            i_in = i_ff + 1'b1;
            j_in = j_ff - 1'b1;
         end
         OP_EMIT_INIT: i_in = '0;
         OP_EMIT_RD: begin
            rd_addr = slot(head_ff, i_ff);
            rd_en = 1'b1;
            i_in = i_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // Second write port is avoided: the high half of a swap is written the cycle after.
   logic          wr2_ff;
   logic [IW-1:0] wr2_addr_ff;
   logic signed [31:0] wr2_data_ff;

   // A read that hits the pending high-half write takes the new word directly.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      else if (wr2_ff) mem[wr2_addr_ff] <= wr2_data_ff;
      if (rd_en) begin
         if (wr2_ff && wr2_addr_ff == rd_addr) rd_ff <= wr2_data_ff;
         else rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         count_ff <= '0;
         wr2_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         count_ff <= count_in;
         wr2_ff <= 1'b0;
         if (cmd.op == OP_SORT_WR && swap_now) begin
            wr2_ff <= 1'b1;
            wr2_addr_ff <= slot(head_ff, i_ff + 1'b1);
            wr2_data_ff <= a_ff;
         end
         if (cmd.op == OP_REV_WR) begin
            wr2_ff <= 1'b1;
            wr2_addr_ff <= slot(head_ff, j_ff);
            wr2_data_ff <= a_ff;
         end
      end
   end

   // a holds the lower position, b the higher; rd_ff arrives in the cycle after its address.
   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      if (cmd.op == OP_LATCH) begin
         func_ff <= req_func;
         val_ff <= req_value;
      end
      if (cmd.op == OP_SORT_CMP) a_ff <= rd_ff;
      if (cmd.op == OP_REV_RD) a_ff <= mem[slot(head_ff, i_ff)];
      if (cmd.op == OP_REV_RD) b_ff <= mem[slot(head_ff, j_ff)];
   end

   // In the write step a_ff holds the lower word and rd_ff the upper one.
   assign swap_now = (a_ff > rd_ff);

   assign status.full = (count_ff >= CAP);
   assign status.empty = (count_ff == '0);
   assign status.sort_done = (k_ff == '0) || (count_ff < CW'(2));
   assign status.swap_needed = swap_now;
   assign status.rev_done = (i_ff >= j_ff) || (count_ff < CW'(2));
   assign status.emit_last = (i_ff == count_ff);
   assign status.func = func_type'(func_ff);

   always_ff @(posedge clock) begin
      if (cmd.one_load) begin
         kind_ff <= cmd.one_kind;
         if (cmd.one_sel_count) oval_ff <= 32'(count_ff);
         else if (cmd.one_sel_front) oval_ff <= mem[slot(head_ff, '0)];
         else if (cmd.one_kind == KIND_ELEM) oval_ff <= mem[slot(head_ff, count_ff - 1'b1)];
         else oval_ff <= '0;
         last_ff <= 1'b1;
      end else if (cmd.op == OP_EMIT_RD) begin
         kind_ff <= KIND_ELEM;
         last_ff <= (i_in == count_ff);
      end
   end

   assign out_kind = kind_ff;
   assign out_value = (cmd.one_load || kind_ff != KIND_ELEM || !last_is_stream) ? oval_ff : rd_ff;
   always_ff @(posedge clock) begin
      if (cmd.one_load) last_is_stream <= 1'b0;
      else if (cmd.op == OP_EMIT_RD) last_is_stream <= 1'b1;
   end
   assign out_last = last_ff;
endmodule
`default_nettype wire

FILE: hdl/deq_ctrl.sv
`default_nettype none
module deq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire deq_pkg::status_type status,
   output deq_pkg::cmd_type      cmd
);
   import deq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            case (status.func)
               FN_PUSH_FRONT, FN_PUSH_BACK:
                  state_in = status.full ? ST_ONE_OUT : ST_EMIT_RD;
               FN_POP_FRONT, FN_POP_BACK:
                  state_in = status.empty ? ST_ONE_OUT : ST_EMIT_RD;
               FN_SORT: state_in = ST_SORT_RD;
               FN_REVERSE: state_in = ST_REV_RD;
               FN_SHOW: state_in = ST_EMIT_RD;
               FN_SIZE, FN_PEEK_FRONT, FN_PEEK_BACK: state_in = ST_ONE_OUT;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_SORT_RD: state_in = status.sort_done ? ST_EMIT_RD : ST_SORT_CMP;
         ST_SORT_CMP: state_in = ST_SORT_WR;
         ST_SORT_WR: state_in = ST_SORT_RD;
         ST_REV_RD: state_in = status.rev_done ? ST_EMIT_RD : ST_REV_WR;
         ST_REV_WR: state_in = ST_REV_RD;
         ST_EMIT_RD: state_in = status.empty ? ST_ONE_OUT : ST_EMIT_OUT;
         ST_EMIT_OUT: if (rsp_ready) state_in = status.emit_last ? ST_IDLE : ST_EMIT_RD;
         ST_ONE_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT_OUT) || (state_ff == ST_ONE_OUT);
      case (state_ff)
         ST_IDLE: cmd.op = OP_LATCH;
         ST_DECODE: begin
            case (status.func)
               FN_PUSH_FRONT: cmd.op = status.full ? OP_NONE : OP_PUSH_FRONT;
               FN_PUSH_BACK: cmd.op = status.full ? OP_NONE : OP_PUSH_BACK;
               FN_POP_FRONT: cmd.op = status.empty ? OP_NONE : OP_POP_FRONT;
               FN_POP_BACK: cmd.op = status.empty ? OP_NONE : OP_POP_BACK;
               FN_SORT: cmd.op = OP_SORT_INIT;
               FN_REVERSE: cmd.op = OP_REV_INIT;
               FN_SHOW: cmd.op = OP_EMIT_INIT;
               FN_CLEAR: cmd.op = OP_CLEAR;
               default: cmd.op = OP_NONE;
            endcase
            cmd.one_load = 1'b1;
            cmd.one_kind = KIND_ERROR;
            case (status.func)
               FN_SIZE: begin
                  cmd.one_kind = KIND_SIZE;
                  cmd.one_sel_count = 1'b1;
               end
               FN_PEEK_FRONT: begin
                  cmd.one_kind = status.empty ? KIND_EMPTY : KIND_ELEM;
                  cmd.one_sel_front = !status.empty;
               end
               FN_PEEK_BACK: cmd.one_kind = status.empty ? KIND_EMPTY : KIND_ELEM;
               default: ;
            endcase
         end
         ST_SORT_RD: cmd.op = status.sort_done ? OP_EMIT_INIT : OP_SORT_RD;
         ST_SORT_CMP: cmd.op = OP_SORT_CMP;
         ST_SORT_WR: cmd.op = OP_SORT_WR;
         ST_REV_RD: cmd.op = status.rev_done ? OP_EMIT_INIT : OP_REV_RD;
         ST_REV_WR: cmd.op = OP_REV_WR;
         ST_EMIT_RD: begin
            if (status.empty) begin
               cmd.one_load = 1'b1;
               cmd.one_kind = KIND_EMPTY;
            end else begin
               cmd.op = OP_EMIT_RD;
            end
         end
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("response valid while accepting a request");
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECODE))
      else $error("accepted request not decoded");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");
endmodule
`default_nettype wire

FILE: hdl/deque_engine_with_sort_reverse.sv
`default_nettype none
// Channel   Dir  Signals
// req       in   valid, ready, func[3:0], value[31:0]
// rsp       out  valid, ready, kind[1:0], value_res[31:0], last
// One request at a time. Push and pop that succeed, and show, then stream out
// the queue; sort runs bubble passes of read, compare and write steps, and
// reverse a read and a write step per swapped pair, with one store write port.
// Synchronous reset empties the queue; store contents are not cleared.
// A stalled response holds the controller in place until it is taken.
module deque_engine_with_sort_reverse #(
   parameter int CAPACITY = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   deq_req_if.sink   req,
   deq_rsp_if.source rsp
);
   import deq_pkg::*;

   cmd_type    cmd;
   status_type status;

   deq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .status(status), .cmd(cmd)
   );

   deq_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_func(req.func), .req_value(req.value),
      .out_kind(rsp.kind), .out_value(rsp.value_res), .out_last(rsp.last)
   );
endmodule
`default_nettype wire
